// File: sv/wfd_pkg.sv
// wfd_pkg: types and constants shared by the wide float divider
// depends on nothing; imported by wfd_prep, wfd_div_stage and wide_float_divider
package wfd_pkg;

    localparam int MANT_W  = 64;
    localparam int EXP_W   = 64;
    localparam int NUM_W   = 2 * MANT_W;
    localparam int N_STEPS = NUM_W;

    localparam logic signed [EXP_W-1:0] EXP_MAX = {1'b0, {(EXP_W-1){1'b1}}};
    localparam logic signed [EXP_W-1:0] EXP_MIN = {1'b1, {(EXP_W-1){1'b0}}};

    localparam logic [EXP_W-1:0] SHIFT_BIG   = EXP_W'(MANT_W - 1);
    localparam logic [EXP_W-1:0] SHIFT_SMALL = EXP_W'(MANT_W);

    // item after the first front stage
    typedef struct packed {
        logic [MANT_W-1:0]        a;
        logic signed [EXP_W-1:0]  ae;
        logic [MANT_W-1:0]        b;
        logic signed [EXP_W-1:0]  sum_e;
        logic                     big;
        logic                     zero;
    } t_pre_item;

    // item travelling through the divide chain
    typedef struct packed {
        logic [MANT_W-1:0]        rem;
        logic [NUM_W-1:0]         num;
        logic [MANT_W-1:0]        d;
        logic signed [EXP_W-1:0]  e;
        logic                     zero;
    } t_div_item;

endpackage

// File: sv/wfd_prep.sv
// wfd_prep: two front stages, zero detect, shift choice and saturated exponent
// depends on wfd_pkg
module wfd_prep import wfd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [MANT_W-1:0]        i_a,
    input  logic signed [EXP_W-1:0]  i_ae,
    input  logic [MANT_W-1:0]        i_b,
    input  logic signed [EXP_W-1:0]  i_be,
    output logic                     o_valid,
    output t_div_item                o_item
);

    t_pre_item         r_pre;
    logic              r_pre_valid;
    t_pre_item         n_pre;
    t_div_item         r_item;
    logic              r_valid;
    t_div_item         n_item;
    logic [EXP_W:0]    w_sum;
    logic [EXP_W:0]    w_diff;

    // stage one: compare, zero check, divisor exponent plus shift with clamp
    always_comb begin
        n_pre.a    = i_a;
        n_pre.ae   = i_ae;
        n_pre.b    = i_b;
        n_pre.big  = (i_a >= i_b);
        n_pre.zero = (i_a == '0) || (i_b == '0);
        w_sum = {i_be[EXP_W-1], i_be} + {1'b0, (n_pre.big ? SHIFT_BIG : SHIFT_SMALL)};
        if (w_sum[EXP_W] != w_sum[EXP_W-1]) begin
            n_pre.sum_e = EXP_MAX;
        end else begin
            n_pre.sum_e = w_sum[EXP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_valid <= 1'b0;
        end else if (i_en) begin
            r_pre_valid <= i_valid;
        end
        if (i_en) begin
            r_pre <= n_pre;
        end
    end

    // stage two: exponent difference with clamp, build the 128-bit dividend
    always_comb begin
        w_diff = {r_pre.ae[EXP_W-1], r_pre.ae} - {r_pre.sum_e[EXP_W-1], r_pre.sum_e};
        if (w_diff[EXP_W] != w_diff[EXP_W-1]) begin
            n_item.e = w_diff[EXP_W] ? EXP_MIN : EXP_MAX;
        end else begin
            n_item.e = w_diff[EXP_W-1:0];
        end
        n_item.rem  = '0;
        n_item.d    = r_pre.b;
        n_item.zero = r_pre.zero;
        if (r_pre.big) begin
            n_item.num = {1'b0, r_pre.a, {(MANT_W-1){1'b0}}};
        end else begin
            n_item.num = {r_pre.a, {MANT_W{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= r_pre_valid;
        end
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: sv/wfd_div_stage.sv
// wfd_div_stage: one restoring division step, one quotient bit per stage
// depends on wfd_pkg
module wfd_div_stage import wfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_div_item  i_item,
    output logic       o_valid,
    output t_div_item  o_item
);

    t_div_item        r_item;
    logic             r_valid;
    t_div_item        n_item;
    logic [MANT_W:0]  w_trial;
    logic             w_fit;

    // shift in the next dividend bit, subtract when the divisor fits
    always_comb begin
        w_trial = {i_item.rem, i_item.num[NUM_W-1]};
        w_fit   = (w_trial >= {1'b0, i_item.d});
        n_item  = i_item;
        if (w_fit) begin
            n_item.rem = MANT_W'(w_trial - {1'b0, i_item.d});
        end else begin
            n_item.rem = w_trial[MANT_W-1:0];
        end
        n_item.num = {i_item.num[NUM_W-2:0], w_fit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: sv/wide_float_divider.sv
// wide_float_divider: top level, front stages, 128-step divide chain, output skid
// depends on wfd_pkg, wfd_prep and wfd_div_stage
//
// channel  direction  signals
// in       input      i_in_valid / o_in_ready, dividend and divisor mantissa, exponent
// out      output     o_out_valid / i_out_ready, quotient mantissa and exponent
//
// one item enters per cycle while the skid register is empty; the path runs through two
// front stages, one stage per quotient bit for all 128 bits, and the output register.
// reset clears every valid bit; payload registers are not reset.
// the whole chain moves together while the skid register is empty; a stalled result
// parks in the skid register, and input is refused only while it is full.
module wide_float_divider import wfd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [MANT_W-1:0]        i_dividend_mantissa,
    input  logic signed [EXP_W-1:0]  i_dividend_exponent,
    input  logic [MANT_W-1:0]        i_divisor_mantissa,
    input  logic signed [EXP_W-1:0]  i_divisor_exponent,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [MANT_W-1:0]        o_quotient_mantissa,
    output logic signed [EXP_W-1:0]  o_quotient_exponent
);

    logic                     w_en;
    t_div_item                w_item  [0:N_STEPS];
    logic                     w_valid [0:N_STEPS];
    logic [MANT_W-1:0]        w_last_m;
    logic signed [EXP_W-1:0]  w_last_e;

    logic                     r_out_valid;
    logic                     n_out_valid;
    logic [MANT_W-1:0]        r_out_m;
    logic [MANT_W-1:0]        n_out_m;
    logic signed [EXP_W-1:0]  r_out_e;
    logic signed [EXP_W-1:0]  n_out_e;
    logic                     r_skid_valid;
    logic                     n_skid_valid;
    logic [MANT_W-1:0]        r_skid_m;
    logic [MANT_W-1:0]        n_skid_m;
    logic signed [EXP_W-1:0]  r_skid_e;
    logic signed [EXP_W-1:0]  n_skid_e;
    logic                     w_out_fire;

    assign w_en       = !r_skid_valid;
    assign o_in_ready = w_en;

    // front stages
    wfd_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_a     (i_dividend_mantissa),
        .i_ae    (i_dividend_exponent),
        .i_b     (i_divisor_mantissa),
        .i_be    (i_divisor_exponent),
        .o_valid (w_valid[0]),
        .o_item  (w_item[0])
    );

    // divide chain, one quotient bit per stage
    for (genvar g = 0; g < N_STEPS; g++) begin : g_step
        wfd_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_item  (w_item[g]),
            .o_valid (w_valid[g+1]),
            .o_item  (w_item[g+1])
        );
    end

    // zero operand forces a zero result
    assign w_last_m = w_item[N_STEPS].zero ? '0 : w_item[N_STEPS].num[MANT_W-1:0];
    assign w_last_e = w_item[N_STEPS].zero ? '0 : w_item[N_STEPS].e;

    assign w_out_fire = r_out_valid && i_out_ready;

    // output register plus skid register
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_m      = r_out_m;
        n_out_e      = r_out_e;
        n_skid_valid = r_skid_valid;
        n_skid_m     = r_skid_m;
        n_skid_e     = r_skid_e;
        if (r_skid_valid) begin
            if (w_out_fire) begin
                n_out_m      = r_skid_m;
                n_out_e      = r_skid_e;
                n_skid_valid = 1'b0;
            end
        end else if (w_valid[N_STEPS]) begin
            if (!r_out_valid || w_out_fire) begin
                n_out_valid = 1'b1;
                n_out_m     = w_last_m;
                n_out_e     = w_last_e;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_m     = w_last_m;
                n_skid_e     = w_last_e;
            end
        end else if (w_out_fire) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_m  <= n_out_m;
        r_out_e  <= n_out_e;
        r_skid_m <= n_skid_m;
        r_skid_e <= n_skid_e;
    end

    assign o_out_valid         = r_out_valid;
    assign o_quotient_mantissa = r_out_m;
    assign o_quotient_exponent = r_out_e;

endmodule

// File: test/wfd_quotient_checker.sv
// wfd_quotient_checker: watches both channels of the wide float divider, predicts each quotient
// and compares it with the result that comes out; depends on wfd_pkg only
module wfd_quotient_checker import wfd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic [MANT_W-1:0]        i_dividend_mantissa,
    input  logic signed [EXP_W-1:0]  i_dividend_exponent,
    input  logic [MANT_W-1:0]        i_divisor_mantissa,
    input  logic signed [EXP_W-1:0]  i_divisor_exponent,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic [MANT_W-1:0]        i_quotient_mantissa,
    input  logic signed [EXP_W-1:0]  i_quotient_exponent,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [MANT_W-1:0]        mantissa;
        logic signed [EXP_W-1:0]  exponent;
    } t_quotient;

    // quotients predicted for accepted items, oldest first
    t_quotient expected_quotients[$];
    int        fails   = 0;
    int        checked = 0;

    // two guard bits so that exponent sums never wrap
    function automatic logic signed [EXP_W+1:0] widen(logic signed [EXP_W-1:0] x);
        return $signed({{2{x[EXP_W-1]}}, x});
    endfunction

    function automatic t_quotient predict_quotient(
        logic [MANT_W-1:0]        a,
        logic signed [EXP_W-1:0]  ae,
        logic [MANT_W-1:0]        b,
        logic signed [EXP_W-1:0]  be
    );
        logic [NUM_W-1:0]          numer;
        logic [NUM_W-1:0]          full_q;
        logic                      a_ge_b;
        logic signed [EXP_W+1:0]   shift_sum;
        logic signed [EXP_W+1:0]   diff;
        logic signed [EXP_W-1:0]   sum_sat;
        t_quotient                 r;

        // zero operand gives a plain zero
        if (a == '0 || b == '0) begin
            r.mantissa = '0;
            r.exponent = '0;
            return r;
        end

        // normalize the dividend so the quotient lands near the top bit
        a_ge_b = (a >= b);
        numer  = a_ge_b ? ({{MANT_W{1'b0}}, a} << (MANT_W - 1))
                        : ({{MANT_W{1'b0}}, a} << MANT_W);
        full_q = numer / {{MANT_W{1'b0}}, b};
        r.mantissa = full_q[MANT_W-1:0];

        // divisor exponent plus shift, clamped high
        shift_sum = widen(be) + widen($signed(a_ge_b ? SHIFT_BIG : SHIFT_SMALL));
        if (shift_sum > widen(EXP_MAX)) begin
            sum_sat = EXP_MAX;
        end else begin
            sum_sat = shift_sum[EXP_W-1:0];
        end

        // difference clamped both ways
        diff = widen(ae) - widen(sum_sat);
        if (diff > widen(EXP_MAX)) begin
            r.exponent = EXP_MAX;
        end else if (diff < widen(EXP_MIN)) begin
            r.exponent = EXP_MIN;
        end else begin
            r.exponent = diff[EXP_W-1:0];
        end
        return r;
    endfunction

    // result side first, so a result never meets the item accepted at the same edge
    always @(posedge i_clk) begin
        t_quotient want;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (expected_quotients.size() == 0) begin
                    $error("result with no item pending: mantissa %h exponent %h",
                           i_quotient_mantissa, i_quotient_exponent);
                    fails++;
                end else begin
                    want = expected_quotients.pop_front();
                    checked++;
                    if (i_quotient_mantissa !== want.mantissa) begin
                        $error("quotient_mantissa mismatch: expected %h, actual %h",
                               want.mantissa, i_quotient_mantissa);
                        fails++;
                    end
                    if (i_quotient_exponent !== want.exponent) begin
                        $error("quotient_exponent mismatch: expected %h, actual %h",
                               want.exponent, i_quotient_exponent);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_quotients.push_back(predict_quotient(
                    i_dividend_mantissa, i_dividend_exponent,
                    i_divisor_mantissa, i_divisor_exponent));
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_quotients.size();
        o_checked    <= checked;
    end

endmodule

// File: test/tb_wide_float_divider.sv
// tb_wide_float_divider: drives the wide float divider with corner and random divisions
// under varying stalls; depends on wfd_pkg, wide_float_divider and wfd_quotient_checker
module tb_wide_float_divider import wfd_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY      = 131;
    localparam int N_RANDOM     = 480;
    localparam int N_PHASES     = 3;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [MANT_W-1:0]        i_dividend_mantissa = '0;
    logic signed [EXP_W-1:0]  i_dividend_exponent = '0;
    logic [MANT_W-1:0]        i_divisor_mantissa = '0;
    logic signed [EXP_W-1:0]  i_divisor_exponent = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [MANT_W-1:0]        o_quotient_mantissa;
    logic signed [EXP_W-1:0]  o_quotient_exponent;

    int fail_count;
    int pending;
    int checked;
    int send_idle_pct = 7;
    int recv_idle_pct = 74;

    always #4 i_clk = ~i_clk;

    wide_float_divider uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_dividend_mantissa (i_dividend_mantissa),
        .i_dividend_exponent (i_dividend_exponent),
        .i_divisor_mantissa  (i_divisor_mantissa),
        .i_divisor_exponent  (i_divisor_exponent),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_quotient_mantissa (o_quotient_mantissa),
        .o_quotient_exponent (o_quotient_exponent)
    );

    wfd_quotient_checker checker_inst (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .i_in_ready          (o_in_ready),
        .i_dividend_mantissa (i_dividend_mantissa),
        .i_dividend_exponent (i_dividend_exponent),
        .i_divisor_mantissa  (i_divisor_mantissa),
        .i_divisor_exponent  (i_divisor_exponent),
        .i_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .i_quotient_mantissa (o_quotient_mantissa),
        .i_quotient_exponent (o_quotient_exponent),
        .o_fail_count        (fail_count),
        .o_pending           (pending),
        .o_checked           (checked)
    );

    // receiver stalls at the current rate
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // random gaps, then hold the item until it is taken
    task automatic send_division(
        logic [MANT_W-1:0]        a,
        logic signed [EXP_W-1:0]  ae,
        logic [MANT_W-1:0]        b,
        logic signed [EXP_W-1:0]  be
    );
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_dividend_mantissa <= a;
        i_dividend_exponent <= ae;
        i_divisor_mantissa  <= b;
        i_divisor_exponent  <= be;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // mix of full-range, tiny, one-hot, near-full and zero mantissas
    function automatic logic [MANT_W-1:0] rand_mantissa();
        case ($urandom_range(9))
            0:       return '0;
            1:       return MANT_W'($urandom_range(15, 1));
            2:       return MANT_W'(1) << $urandom_range(MANT_W - 1);
            3:       return ~MANT_W'($urandom_range(15));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // mix of full-range, near-limit and small exponents
    function automatic logic signed [EXP_W-1:0] rand_exponent();
        case ($urandom_range(7))
            0:       return EXP_MAX - EXP_W'($urandom_range(130));
            1:       return EXP_MIN + EXP_W'($urandom_range(130));
            2:       return $signed(EXP_W'($urandom_range(400))) - 64'sd200;
            default: return $signed({$urandom, $urandom});
        endcase
    endfunction

    initial begin
        logic [MANT_W-1:0] a;
        logic [MANT_W-1:0] b;
        int                waited;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero operands, whatever the exponents
        send_division('0, EXP_MAX, 64'd5, EXP_MIN);
        send_division(64'd7, -64'sd3, '0, 64'sd12);
        send_division('0, EXP_MIN, '0, EXP_MAX);
        // unit, wide quotient, tiny quotient, equal and off-by-one mantissas
        send_division(64'd1, 64'sd0, 64'd1, 64'sd0);
        send_division('1, 64'sd10, 64'd1, -64'sd10);
        send_division(64'd1, 64'sd0, '1, 64'sd0);
        send_division('1, 64'sd1, '1, 64'sd1);
        send_division('1 - 64'd1, 64'sd0, '1, 64'sd0);
        send_division(64'h8000_0000_0000_0000, 64'sd0, 64'd3, 64'sd0);
        send_division(64'd12345, 64'sd5, 64'd12346, -64'sd5);
        send_division(64'd3, 64'sd100, 64'd2, 64'sd7);
        // exponent saturation on the sum and on the difference
        send_division(64'd9, 64'sd0, 64'd4, EXP_MAX);
        send_division(64'd9, 64'sd0, 64'd4, EXP_MAX - 64'sd63);
        send_division(64'd4, 64'sd0, 64'd9, EXP_MAX - 64'sd63);
        send_division(64'd5, EXP_MIN, 64'd3, 64'sd1);
        send_division(64'd5, EXP_MAX, 64'd3, EXP_MIN);
        send_division(64'd3, EXP_MAX, 64'd5, EXP_MIN);
        send_division(64'd5, EXP_MIN, 64'd3, EXP_MAX);
        send_division(64'd5, EXP_MIN, 64'd3, -64'sd63);
        send_division(64'd3, EXP_MIN + 64'sd64, 64'd5, 64'sd0);
        send_division('1, EXP_MAX, 64'd1, EXP_MAX);

        // random part in three stall mixes
        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 7;  recv_idle_pct = 74; end
                1:       begin send_idle_pct = 74; recv_idle_pct = 7;  end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            for (int n = 0; n < N_RANDOM / N_PHASES; n++) begin
                a = rand_mantissa();
                if ($urandom_range(3) == 0) begin
                    b = a + MANT_W'($urandom_range(4)) - MANT_W'(2);
                end else begin
                    b = rand_mantissa();
                end
                send_division(a, rand_exponent(), b, rand_exponent());
            end
        end
        i_in_valid <= 1'b0;

        // drain, then watch for stray results
        while (pending != 0) @(posedge i_clk);
        waited = 0;
        while (waited < LATENCY + 20) begin
            @(posedge i_clk);
            waited++;
        end

        $display("%0d quotients checked: zero, wide-quotient and saturation corners, then",
                 checked);
        $display("random operands under sender-heavy, receiver-heavy and no stalls");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
sv/wfd_pkg.sv
sv/wfd_prep.sv
sv/wfd_div_stage.sv
sv/wide_float_divider.sv
test/wfd_quotient_checker.sv
test/tb_wide_float_divider.sv
